// ===== hdl/sbck_pkg.sv =====
`timescale 1ns / 1ps

package sbck_pkg;

   localparam int DIM_BITS_DEF   = 12;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int INDEX_BITS     = 24;
   localparam int ACC_BITS       = 32;
   localparam int POS_BITS       = 16;
   localparam int SIZE_BITS      = 15;
   localparam int PIX_BITS       = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SRC_WIDTH     = 3'd0,
      CSR_SRC_HEIGHT    = 3'd1,
      CSR_SRC_ROW_PITCH = 3'd2,
      CSR_DST_WIDTH     = 3'd3,
      CSR_DST_HEIGHT    = 3'd4,
      CSR_DST_ROW_PITCH = 3'd5,
      CSR_KEY_COLOUR    = 3'd6,
      CSR_KEY_ENABLE    = 3'd7
   } csr_index_type;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                       req_type;
      logic signed [POS_BITS-1:0] dst_x;
      logic signed [POS_BITS-1:0] dst_y;
      logic [SIZE_BITS-1:0]       out_width;
      logic [SIZE_BITS-1:0]       out_height;
      logic [PIX_BITS-1:0]        pixel;
   } req_word_type;

   typedef struct packed {
      logic                  fetch_valid;
      logic [INDEX_BITS-1:0] src_index;
      logic                  write_enable;
      logic [INDEX_BITS-1:0] dst_index;
      logic [PIX_BITS-1:0]   write_data;
      logic                  last;
   } rsp_word_type;

   typedef struct packed {
      logic load_start;
      logic clip;
      logic div_start;
      logic div_sel_y;
      logic store_step_x;
      logic store_step_y;
      logic mul_x;
      logic mul_y;
      logic row_base;
      logic pixel;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic div_done;
      logic pend_last;
   } dp_status_type;

endpackage

// ===== hdl/sbck_div.sv =====
`timescale 1ns / 1ps

module sbck_div #(
   parameter int DIM_BITS  = sbck_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = sbck_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [DIM_BITS-1:0]                  dim,
   input  logic [sbck_pkg::SIZE_BITS-1:0]       divisor,
   output logic                                 done,
   output logic [DIM_BITS+FRAC_BITS-1:0]        quotient
);
   import sbck_pkg::*;

   localparam int Q_BITS   = DIM_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(Q_BITS + 1);

   logic [Q_BITS-1:0]    num_ff;
   logic [SIZE_BITS-1:0] rem_ff;
   logic [SIZE_BITS-1:0] rem_in;
   logic [SIZE_BITS-1:0] divisor_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [SIZE_BITS:0]   trial;
   logic                 fits;

   // restoring division, one quotient bit per cycle shifted into num_ff
   always_comb begin
      trial  = {rem_ff, num_ff[Q_BITS-1]};
      fits   = trial >= {1'b0, divisor_ff};
      rem_in = fits ? SIZE_BITS'(trial - {1'b0, divisor_ff}) : SIZE_BITS'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff     <= {dim, {FRAC_BITS{1'b0}}};
            rem_ff     <= '0;
            divisor_ff <= divisor;
            count_ff   <= CNT_BITS'(Q_BITS);
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            num_ff   <= {num_ff[Q_BITS-2:0], fits};
            rem_ff   <= rem_in;
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

// ===== hdl/sbck_dp.sv =====
`timescale 1ns / 1ps

module sbck_dp #(
   parameter int DIM_BITS  = sbck_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = sbck_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [sbck_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sbck_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  sbck_pkg::req_word_type              req_word,
   input  sbck_pkg::dp_cmd_type                cmd,
   output sbck_pkg::dp_status_type             status,
   output sbck_pkg::rsp_word_type              rsp_word
);
   import sbck_pkg::*;

   localparam int Q_BITS    = DIM_BITS + FRAC_BITS;
   localparam int ROW_BITS  = ACC_BITS - FRAC_BITS;
   localparam int SPAN_BITS = POS_BITS + 2;

   typedef struct packed {
      logic                empty;
      logic [DIM_BITS-1:0] len;
      logic [DIM_BITS-1:0] origin;
      logic [POS_BITS-1:0] skip;
   } axis_type;

   // clip one axis: negative position eats into the run, far edge cuts it
   function automatic axis_type clip_axis(input logic [POS_BITS-1:0]  pos,
                                          input logic [SIZE_BITS-1:0] size,
                                          input logic [DIM_BITS-1:0]  limit);
      logic signed [SPAN_BITS-1:0] p;
      logic signed [SPAN_BITS-1:0] s;
      logic signed [SPAN_BITS-1:0] lim;
      logic signed [SPAN_BITS-1:0] run;
      logic signed [SPAN_BITS-1:0] org;
      logic                        neg;
      axis_type                    r;
      neg = pos[POS_BITS-1];
      p   = SPAN_BITS'(signed'(pos));
      s   = SPAN_BITS'(size);
      lim = SPAN_BITS'(limit);
      run = neg ? s + p : s;
      org = neg ? '0 : p;
      if (run + org >= lim) begin
         run = lim - org;
      end
      r.empty  = run[SPAN_BITS-1] || (run == '0);
      r.len    = DIM_BITS'(run);
      r.origin = DIM_BITS'(org);
      r.skip   = neg ? (~pos + 1'b1) : '0;
      return r;
   endfunction

   logic [DIM_BITS-1:0]    src_width_ff;
   logic [DIM_BITS-1:0]    src_height_ff;
   logic [DIM_BITS-1:0]    src_row_pitch_ff;
   logic [DIM_BITS-1:0]    dst_width_ff;
   logic [DIM_BITS-1:0]    dst_height_ff;
   logic [DIM_BITS-1:0]    dst_row_pitch_ff;
   logic [PIX_BITS-1:0]    key_colour_ff;
   logic                   key_enable_ff;

   req_word_type           start_ff;
   logic [Q_BITS-1:0]      step_x_ff;
   logic [Q_BITS-1:0]      step_y_ff;
   logic [POS_BITS-1:0]    skip_x_ff;
   logic [POS_BITS-1:0]    skip_y_ff;
   logic [DIM_BITS-1:0]    clip_w_ff;
   logic [DIM_BITS-1:0]    clip_h_ff;
   logic [DIM_BITS-1:0]    origin_x_ff;
   logic [DIM_BITS-1:0]    origin_y_ff;
   logic [DIM_BITS-1:0]    col_ff;
   logic [DIM_BITS-1:0]    row_ff;
   logic [ACC_BITS-1:0]    acc_x_ff;
   logic [ACC_BITS-1:0]    acc_y_ff;
   logic [ACC_BITS-1:0]    start_x_ff;
   logic [INDEX_BITS-1:0]  row_base_ff;
   logic                   pend_we_ff;
   logic [INDEX_BITS-1:0]  pend_di_ff;
   logic [PIX_BITS-1:0]    pend_pix_ff;
   logic                   pend_last_ff;
   rsp_word_type           rsp_ff;

   axis_type               ax_x;
   axis_type               ax_y;
   logic                   div_done;
   logic [Q_BITS-1:0]      div_quot;
   logic [DIM_BITS-1:0]    div_dim;
   logic [SIZE_BITS-1:0]   div_divisor;

   logic [DIM_BITS-1:0]    col_step;
   logic                   wrap;
   logic [DIM_BITS-1:0]    col_in;
   logic [DIM_BITS-1:0]    row_in;
   logic [ACC_BITS-1:0]    acc_x_in;
   logic [ACC_BITS-1:0]    acc_y_in;
   logic [INDEX_BITS-1:0]  row_base_in;
   logic                   last_in;
   logic [INDEX_BITS-1:0]  di_in;
   logic                   we_in;

   logic [POS_BITS+Q_BITS-1:0]   skip_prod;
   logic [2*DIM_BITS-1:0]        base_prod;
   logic [ROW_BITS+DIM_BITS-1:0] row_prod;
   logic [INDEX_BITS-1:0]        src_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= DIM_BITS'(1);
         src_height_ff    <= DIM_BITS'(1);
         src_row_pitch_ff <= DIM_BITS'(1);
         dst_width_ff     <= DIM_BITS'(1);
         dst_height_ff    <= DIM_BITS'(1);
         dst_row_pitch_ff <= DIM_BITS'(1);
         key_colour_ff    <= '0;
         key_enable_ff    <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:     src_width_ff     <= csr_data[DIM_BITS-1:0];
            CSR_SRC_HEIGHT:    src_height_ff    <= csr_data[DIM_BITS-1:0];
            CSR_SRC_ROW_PITCH: src_row_pitch_ff <= csr_data[DIM_BITS-1:0];
            CSR_DST_WIDTH:     dst_width_ff     <= csr_data[DIM_BITS-1:0];
            CSR_DST_HEIGHT:    dst_height_ff    <= csr_data[DIM_BITS-1:0];
            CSR_DST_ROW_PITCH: dst_row_pitch_ff <= csr_data[DIM_BITS-1:0];
            CSR_KEY_COLOUR:    key_colour_ff    <= csr_data[PIX_BITS-1:0];
            CSR_KEY_ENABLE:    key_enable_ff    <= csr_data[0];
         endcase
      end
   end

   assign ax_x = clip_axis(start_ff.dst_x, start_ff.out_width, dst_width_ff);
   assign ax_y = clip_axis(start_ff.dst_y, start_ff.out_height, dst_height_ff);

   assign div_dim     = cmd.div_sel_y ? src_height_ff : src_width_ff;
   assign div_divisor = cmd.div_sel_y ? start_ff.out_height : start_ff.out_width;

   sbck_div #(
      .DIM_BITS  (DIM_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dim      (div_dim),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // pixel step: advance column, wrap to next row at the clipped width
   always_comb begin
      col_step    = col_ff + 1'b1;
      wrap        = col_step >= clip_w_ff;
      col_in      = wrap ? '0 : col_step;
      row_in      = wrap ? row_ff + 1'b1 : row_ff;
      acc_x_in    = wrap ? start_x_ff : acc_x_ff + ACC_BITS'(step_x_ff);
      acc_y_in    = wrap ? acc_y_ff + ACC_BITS'(step_y_ff) : acc_y_ff;
      row_base_in = wrap ? row_base_ff + INDEX_BITS'(dst_row_pitch_ff) : row_base_ff;
      last_in     = row_in >= clip_h_ff;
      di_in       = row_base_ff + INDEX_BITS'(origin_x_ff) + INDEX_BITS'(col_ff);
      we_in       = !(key_enable_ff && (req_word.pixel == key_colour_ff));
   end

   always_comb begin
      skip_prod = (cmd.mul_y ? skip_y_ff : skip_x_ff) * (cmd.mul_y ? step_y_ff : step_x_ff);
      base_prod = origin_y_ff * dst_row_pitch_ff;
      row_prod  = acc_y_ff[ACC_BITS-1:FRAC_BITS] * src_row_pitch_ff;
      src_idx   = INDEX_BITS'(row_prod) + INDEX_BITS'(acc_x_ff[ACC_BITS-1:FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         start_ff <= req_word;
      end
      if (cmd.clip) begin
         clip_w_ff    <= ax_x.len;
         clip_h_ff    <= ax_y.len;
         origin_x_ff  <= ax_x.origin;
         origin_y_ff  <= ax_y.origin;
         skip_x_ff    <= ax_x.skip;
         skip_y_ff    <= ax_y.skip;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_we_ff   <= 1'b0;
         pend_di_ff   <= '0;
         pend_pix_ff  <= '0;
         pend_last_ff <= ax_x.empty | ax_y.empty;
      end
      if (cmd.store_step_x) begin
         step_x_ff <= div_quot;
      end
      if (cmd.store_step_y) begin
         step_y_ff <= div_quot;
      end
      if (cmd.mul_x) begin
         start_x_ff <= ACC_BITS'(skip_prod);
         acc_x_ff   <= ACC_BITS'(skip_prod);
      end
      if (cmd.mul_y) begin
         acc_y_ff <= ACC_BITS'(skip_prod);
      end
      if (cmd.row_base) begin
         row_base_ff <= INDEX_BITS'(base_prod);
      end
      if (cmd.pixel) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         row_base_ff  <= row_base_in;
         pend_we_ff   <= we_in;
         pend_di_ff   <= di_in;
         pend_pix_ff  <= req_word.pixel;
         pend_last_ff <= last_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff.fetch_valid  <= !pend_last_ff;
         rsp_ff.src_index    <= pend_last_ff ? '0 : src_idx;
         rsp_ff.write_enable <= pend_we_ff;
         rsp_ff.dst_index    <= pend_di_ff;
         rsp_ff.write_data   <= pend_pix_ff;
         rsp_ff.last         <= pend_last_ff;
      end
   end

   assign status.empty     = ax_x.empty | ax_y.empty;
   assign status.div_done  = div_done;
   assign status.pend_last = pend_last_ff;
   assign rsp_word         = rsp_ff;

endmodule

// ===== hdl/sbck_ctrl.sv =====
`timescale 1ns / 1ps

module sbck_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sbck_pkg::dp_status_type status,
   output sbck_pkg::dp_cmd_type    cmd
);
   import sbck_pkg::*;

   typedef enum logic [2:0] {
      S_WAIT,
      S_CLIP,
      S_DIVX,
      S_MULX,
      S_DIVY,
      S_MULY,
      S_ROWB,
      S_INDEX
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      active_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_WAIT: begin
            if (req_valid) begin
               if (req_kind == REQ_START) begin
                  cmd.load_start = 1'b1;
                  state_in       = S_CLIP;
               end else if (active_ff) begin
                  cmd.pixel = 1'b1;
                  state_in  = S_INDEX;
               end
               // pixel word with no blit running is dropped
            end
         end
         S_CLIP: begin
            cmd.clip = 1'b1;
            if (status.empty) begin
               state_in = S_INDEX;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVX;
            end
         end
         S_DIVX: begin
            if (status.div_done) begin
               cmd.store_step_x = 1'b1;
               state_in         = S_MULX;
            end
         end
         S_MULX: begin
            cmd.mul_x     = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in      = S_DIVY;
         end
         S_DIVY: begin
            cmd.div_sel_y = 1'b1;
            if (status.div_done) begin
               cmd.store_step_y = 1'b1;
               state_in         = S_MULY;
            end
         end
         S_MULY: begin
            cmd.mul_y = 1'b1;
            state_in  = S_ROWB;
         end
         S_ROWB: begin
            cmd.row_base = 1'b1;
            state_in     = S_INDEX;
         end
         S_INDEX: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_WAIT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WAIT;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
            active_ff    <= !status.pend_last;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_WAIT);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/scaled_blit_color_key.sv =====
`timescale 1ns / 1ps

// Nearest-neighbor scaled blit with color key, 16-bit pixels.
// req_* carries start words (position, output size) and pixel words (fetched
// source pixel). rsp_* returns one word per start and per pixel of a running
// blit: next source index to fetch, destination write, last flag. csr_*
// writes the eight setup registers and is always ready.
// Start: steps come from a shared 1-bit-per-cycle divider run twice, once for
// x and once for y, before the response is loaded. A start that clips to
// nothing skips the divider and goes from the clip state straight to the response.
// Pixel: the word is taken in the wait state; the response register loads in
// the index state once the output register is free, and the source index
// multiply sits in that state. No new word is taken until that load.
// A pixel word while no blit runs is taken and dropped.
// A start while a blit runs abandons it.
// If rsp_ready is low the finished word holds in the output register; the
// next word is still accepted, and its response waits until the register
// frees. Reset (synchronous) idles the engine and restores register defaults.
module scaled_blit_color_key #(
   parameter int DIM_BITS  = sbck_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = sbck_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sbck_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sbck_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbck_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sbck_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import sbck_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   sbck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_word.req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbck_dp #(
      .DIM_BITS  (DIM_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sbck_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 11;
   localparam int SETTLE       = 80;      // longer than a start takes, with margin
   localparam int LIMIT_CYCLES = 600000;
   localparam int PHASE_ITEMS  = 100;
   localparam int RAND_PHASES  = 6;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   scaled_blit_color_key dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // register mirror
   logic [11:0] cfg_src_w = 12'd1;
   logic [11:0] cfg_src_h = 12'd1;
   logic [11:0] cfg_src_pitch = 12'd1;
   logic [11:0] cfg_dst_w = 12'd1;
   logic [11:0] cfg_dst_h = 12'd1;
   logic [11:0] cfg_dst_pitch = 12'd1;
   logic [15:0] cfg_key = 16'd0;
   logic        cfg_key_en = 1'b0;

   // blit engine state
   bit          blit_active = 1'b0;
   logic [31:0] blit_step_x = '0;
   logic [31:0] blit_step_y = '0;
   logic [31:0] blit_row_start_x = '0;
   logic [31:0] blit_acc_x = '0;
   logic [31:0] blit_acc_y = '0;
   int          blit_clip_w = 0;
   int          blit_clip_h = 0;
   int          blit_col = 0;
   int          blit_row = 0;
   logic [23:0] blit_dst_base = '0;
   logic [11:0] blit_dst_origin = '0;

   req_word_type req_backlog[$];
   rsp_word_type due_rsp[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          req_fired = 1'b0;
   int          pushed_count = 0;
   int          accepted_count = 0;
   int          err_count = 0;
   int          rsp_checked = 0;
   int          starts_taken = 0;
   int          pixels_taken = 0;
   int          cycle_count = 0;

   task automatic report_mismatch(input string msg);
      if (err_count < 100) $display("ERROR @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h want %h", rsp_checked,
                                   name, got, want));
   endtask

   // Clip a start word against the destination; returns 1 when something is left.
   function automatic bit clip_rect(input req_word_type w, output int cx, output int cy,
                                    output int cw, output int ch,
                                    output logic [31:0] stx, output logic [31:0] sty,
                                    output logic [31:0] sxa, output logic [31:0] sya);
      cx = int'(w.dst_x);
      cy = int'(w.dst_y);
      cw = int'(w.out_width);
      ch = int'(w.out_height);
      stx = '0;
      sty = '0;
      sxa = '0;
      sya = '0;
      if (cw == 0 || ch == 0) return 1'b0;
      stx = 32'((64'(cfg_src_w) << 16) / 64'(cw));
      sty = 32'((64'(cfg_src_h) << 16) / 64'(ch));
      if (cx < 0) begin
         cw += cx;
         sxa = 32'(64'(-cx) * 64'(stx));
         cx = 0;
      end
      if (cy < 0) begin
         ch += cy;
         sya = 32'(64'(-cy) * 64'(sty));
         cy = 0;
      end
      if (cw + cx >= int'(cfg_dst_w)) cw = int'(cfg_dst_w) - cx;
      if (ch + cy >= int'(cfg_dst_h)) ch = int'(cfg_dst_h) - cy;
      return (cw > 0 && ch > 0);
   endfunction

   function automatic logic [23:0] src_index_now();
      return 24'(64'(blit_acc_y[31:16]) * 64'(cfg_src_pitch) + 64'(blit_acc_x[31:16]));
   endfunction

   // Update the engine state for one accepted word and queue the response it causes.
   task automatic advance_blit(input req_word_type w);
      rsp_word_type r;
      int cx, cy, cw, ch;
      logic [31:0] stx, sty, sxa, sya;
      logic [23:0] di;
      r = '0;
      if (w.req_type == REQ_START) begin
         blit_active = 1'b0;
         if (clip_rect(w, cx, cy, cw, ch, stx, sty, sxa, sya)) begin
            blit_step_x = stx;
            blit_step_y = sty;
            blit_row_start_x = sxa;
            blit_acc_x = sxa;
            blit_acc_y = sya;
            blit_clip_w = cw;
            blit_clip_h = ch;
            blit_col = 0;
            blit_row = 0;
            blit_dst_base = 24'(64'(cy) * 64'(cfg_dst_pitch));
            blit_dst_origin = cx[11:0];
            blit_active = 1'b1;
            r.fetch_valid = 1'b1;
            r.src_index = src_index_now();
         end else begin
            r.last = 1'b1;
         end
         due_rsp.push_back(r);
      end else if (blit_active) begin
         di = 24'(64'(blit_dst_base) + 64'(blit_dst_origin) + 64'(blit_col));
         r.write_enable = !(cfg_key_en && w.pixel == cfg_key);
         r.dst_index = di;
         r.write_data = w.pixel;
         blit_col++;
         blit_acc_x += blit_step_x;
         if (blit_col >= blit_clip_w) begin
            blit_col = 0;
            blit_row++;
            blit_acc_y += blit_step_y;
            blit_acc_x = blit_row_start_x;
            blit_dst_base += 24'(cfg_dst_pitch);
         end
         if (blit_row >= blit_clip_h) begin
            blit_active = 1'b0;
            r.last = 1'b1;
         end else begin
            r.fetch_valid = 1'b1;
            r.src_index = src_index_now();
         end
         due_rsp.push_back(r);
      end
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fired) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_word  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: check responses first, then predict from the word taken this edge
   always @(posedge clock) begin
      rsp_word_type want;
      req_fired <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %h", rsp_word));
            end else begin
               want = due_rsp.pop_front();
               check_field("fetch_valid", 32'(rsp_word.fetch_valid), 32'(want.fetch_valid));
               check_field("src_index", 32'(rsp_word.src_index), 32'(want.src_index));
               check_field("write_enable", 32'(rsp_word.write_enable),
                           32'(want.write_enable));
               check_field("dst_index", 32'(rsp_word.dst_index), 32'(want.dst_index));
               check_field("write_data", 32'(rsp_word.write_data), 32'(want.write_data));
               check_field("last", 32'(rsp_word.last), 32'(want.last));
            end
            rsp_checked++;
         end
         if (req_valid && req_ready) begin
            advance_blit(req_word);
            accepted_count++;
            if (req_word.req_type == REQ_START) starts_taken++;
            else pixels_taken++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SRC_WIDTH:     cfg_src_w = csr_data[11:0];
               CSR_SRC_HEIGHT:    cfg_src_h = csr_data[11:0];
               CSR_SRC_ROW_PITCH: cfg_src_pitch = csr_data[11:0];
               CSR_DST_WIDTH:     cfg_dst_w = csr_data[11:0];
               CSR_DST_HEIGHT:    cfg_dst_h = csr_data[11:0];
               CSR_DST_ROW_PITCH: cfg_dst_pitch = csr_data[11:0];
               CSR_KEY_COLOUR:    cfg_key = csr_data;
               CSR_KEY_ENABLE:    cfg_key_en = csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
                  due_rsp.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int sw, input int sh, input int sp, input int dw,
                             input int dh, input int dp, input logic [15:0] key,
                             input bit ke);
      write_reg(CSR_SRC_WIDTH, 16'(sw));
      write_reg(CSR_SRC_HEIGHT, 16'(sh));
      write_reg(CSR_SRC_ROW_PITCH, 16'(sp));
      write_reg(CSR_DST_WIDTH, 16'(dw));
      write_reg(CSR_DST_HEIGHT, 16'(dh));
      write_reg(CSR_DST_ROW_PITCH, 16'(dp));
      write_reg(CSR_KEY_COLOUR, key);
      write_reg(CSR_KEY_ENABLE, {15'($urandom), ke});
      @(posedge clock);
   endtask

   // wait until every word is taken and every response seen; returns on a rising edge
   task automatic wait_drain();
      do @(negedge clock); while (!(accepted_count == pushed_count && due_rsp.size() == 0));
      @(posedge clock);
   endtask

   task automatic push_item(input req_word_type w);
      req_backlog.push_back(w);
      pushed_count++;
   endtask

   function automatic req_word_type start_word(input int x, input int y, input int w,
                                               input int h);
      req_word_type r;
      r.req_type   = REQ_START;
      r.dst_x      = x[15:0];
      r.dst_y      = y[15:0];
      r.out_width  = w[14:0];
      r.out_height = h[14:0];
      r.pixel      = 16'($urandom);
      return r;
   endfunction

   function automatic req_word_type pixel_word(input logic [15:0] p);
      req_word_type r;
      r.req_type   = REQ_PIXEL;
      r.dst_x      = 16'($urandom);
      r.dst_y      = 16'($urandom);
      r.out_width  = 15'($urandom);
      r.out_height = 15'($urandom);
      r.pixel      = p;
      return r;
   endfunction

   function automatic logic [15:0] rand_pixel();
      return ($urandom_range(0, 3) == 0) ? cfg_key : 16'($urandom);
   endfunction

   // start word plus its pixels; big or truncated blits get cut short and abandoned
   task automatic push_blit(input int x, input int y, input int w, input int h,
                            input bit trunc, output int made);
      req_word_type s;
      int cx, cy, cw, ch, n;
      logic [31:0] stx, sty, sxa, sya;
      s = start_word(x, y, w, h);
      n = clip_rect(s, cx, cy, cw, ch, stx, sty, sxa, sya) ? cw * ch : 0;
      if (n > 256) n = $urandom_range(0, 64);
      else if (trunc && n > 0) n = $urandom_range(0, n - 1);
      push_item(s);
      for (int i = 0; i < n; i++) push_item(pixel_word(rand_pixel()));
      made = 1 + n;
   endtask

   task automatic random_blit(output int made);
      int kind, x, y, w, h;
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
         x = $urandom_range(0, 8);
         y = $urandom_range(0, 8);
         w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 32767);
         h = (w != 0) ? 0 : $urandom_range(0, 32767);
         push_blit(x, y, w, h, 1'b0, made);
      end else if (kind < 14) begin
         // noise over the full field ranges
         x = int'($signed(16'($urandom)));
         y = int'($signed(16'($urandom)));
         push_blit(x, y, $urandom_range(0, 32767), $urandom_range(0, 32767), 1'b0, made);
      end else begin
         x = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 40))
                                         : int'($urandom_range(0, cfg_dst_w - 1));
         y = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 40))
                                         : int'($urandom_range(0, cfg_dst_h - 1));
         w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 24);
         h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 24);
         push_blit(x, y, w, h, ($urandom_range(0, 9) == 0), made);
         // stray pixel after the blit's words, dropped by the block when no blit runs
         if (!blit_active && $urandom_range(0, 19) == 0) push_item(pixel_word(rand_pixel()));
      end
   endtask

   function automatic int rand_dim();
      case ($urandom_range(0, 5))
         0: return 1;
         1: return 4095;
         default: return $urandom_range(1, 4095);
      endcase
   endfunction

   function automatic int rand_dst_dim();
      case ($urandom_range(0, 7))
         0: return 1;
         1: return 4095;
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   initial begin
      int made, count;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      set_config(8, 6, 10, 16, 12, 20, 16'h1234, 1'b1);
      push_item(pixel_word(16'hFFFF));                // pixel with no blit running
      push_blit(0, 0, 0, 5, 1'b0, made);              // zero width
      push_blit(0, 0, 5, 0, 1'b0, made);              // zero height
      push_blit(-3, -2, 4, 3, 1'b0, made);            // negative position, clipped to 1x1
      push_blit(-32768, -32768, 32767, 32767, 1'b0, made);
      push_blit(32767, 0, 32767, 1, 1'b0, made);      // off the right edge
      push_item(start_word(0, 0, 3, 3));              // abandoned by the next start
      push_item(pixel_word(16'h0000));
      push_item(pixel_word(16'h1234));
      push_blit(5, 5, 1, 1, 1'b0, made);
      push_blit(14, 10, 32767, 32767, 1'b0, made);    // right and bottom clip
      // sender holds mid-blit until everything is back
      push_item(start_word(1, 1, 2, 2));
      push_item(pixel_word(16'h1234));
      push_item(pixel_word(16'hFFFF));
      wait_drain();
      push_item(pixel_word(16'h0000));
      push_item(pixel_word(16'h5A5A));
      wait_drain();
      repeat (SETTLE) @(posedge clock);

      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: set_config(1, 1, 1, 1, 1, 1, 16'h0000, 1'b1);
            1: set_config(4095, 4095, 4095, 4095, 4095, 4095, 16'hFFFF, 1'b1);
            default: set_config(rand_dim(), rand_dim(), rand_dim(), rand_dst_dim(),
                                rand_dst_dim(), rand_dim(), 16'($urandom), p[0]);
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            random_blit(made);
            count += made;
         end
         wait_drain();
         repeat (SETTLE) @(posedge clock);
      end

      $display("Covered %0d setup phases: %0d starts and %0d pixel words taken,",
               RAND_PHASES + 1, starts_taken, pixels_taken);
      $display("%0d response words checked under varied idling and stalls", rsp_checked);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sbck_pkg.sv
hdl/sbck_div.sv
hdl/sbck_dp.sv
hdl/sbck_ctrl.sv
hdl/scaled_blit_color_key.sv
sim/tb_top.sv
